// ===== sv/bcat_pkg.sv =====
// Shared types and constants for the block chain allocation table.
// Holds field widths, operation and status codes, FSM state and the
// controller/datapath command and status structs. No dependencies.
package bcat_pkg;

	localparam int BLK_W   = 16;
	localparam int VAL_W   = 17;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int ENT_W   = 11;
	localparam int CIDX_W  = 4;
	localparam int CDATA_W = 16;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_FOLLOW = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EXTEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BROKEN = 2'd3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_FIRST_BLOCK    = 4'd0;
	localparam logic [CIDX_W-1:0] CFG_ENTRIES_IN_USE = 4'd1;

	// link entry codes
	localparam logic [BLK_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [BLK_W-1:0] LINK_END  = 16'hFFFF;

	localparam logic [15:0] FIRST_BLOCK_RST = 16'd0;
	localparam logic [10:0] ENTRIES_RST     = 11'd1024;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_EVAL,
		S_SCAN_RD,
		S_SCAN_CK,
		S_LINK,
		S_FINISH
	} state_t;

	typedef enum logic {
		ADDR_CUR,
		ADDR_SCAN
	} addr_sel_t;

	typedef enum logic [1:0] {
		WR_ZERO,
		WR_END,
		WR_LINK
	} wr_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ENTRY,
		RES_SCAN
	} res_sel_t;

	typedef struct packed {
		logic              req_ready;
		logic              rd_en;
		logic              wr_en;
		addr_sel_t         addr_sel;
		wr_sel_t           wr_sel;
		logic              cur_load;
		logic              cnt_clr;
		logic              cnt_inc;
		logic              res_set;
		res_sel_t          res_sel;
		logic [STAT_W-1:0] res_status;
		logic              out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic              req_fire;
		logic [FUNC_W-1:0] func;
		logic              none;
		logic              in_range;
		logic              ent_zero;
		logic              ent_end;
		logic              scan_end;
		logic              scan_hit;
		logic              clr_last;
		logic              out_free;
	} ctl_stat_t;

endpackage

// ===== sv/bcat_req_if.sv =====
// Request channel: operation code and block number with valid/ready.
// Depends on bcat_pkg for field widths.
interface bcat_req_if;
	import bcat_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [VAL_W-1:0]  block;

	modport source (output valid, output func, output block, input ready);
	modport sink (input valid, input func, input block, output ready);
endinterface

// ===== sv/bcat_rsp_if.sv =====
// Result channel: returned block number and status with valid/ready.
// Depends on bcat_pkg for field widths.
interface bcat_rsp_if;
	import bcat_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  value;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ===== sv/bcat_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
// Depends on bcat_pkg for field widths.
interface bcat_cfg_if;
	import bcat_pkg::*;

	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/bcat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bcat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/bcat_datapath.sv =====
// Datapath: configuration registers, link table RAM, current block and
// scan counter, range checks, result and output registers.
// Depends on bcat_pkg, the channel interfaces and bcat_ram.
module bcat_datapath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcat_pkg::ctl_cmd_t   cmd,
	output bcat_pkg::ctl_stat_t  stat,
	bcat_req_if.sink             req,
	bcat_rsp_if.source           rsp,
	bcat_cfg_if.sink             cfg
);
	import bcat_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int VW = IW + 1;
	localparam int CW = (VW > ENT_W) ? VW : ENT_W;

	logic [BLK_W-1:0]  first_q;
	logic [ENT_W-1:0]  entries_q;
	logic [FUNC_W-1:0] func_q;
	logic              none_q;
	logic [BLK_W-1:0]  cur_q;
	logic [VW-1:0]     scan_q;
	logic [VAL_W-1:0]  res_value_q;
	logic [STAT_W-1:0] res_status_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [STAT_W-1:0] out_status_q;

	logic [VW-1:0]     valid_cnt;
	logic [BLK_W-1:0]  cur_off;
	logic [IW-1:0]     cur_idx;
	logic [VAL_W-1:0]  scan_num;
	logic              scan_usable;
	logic [IW-1:0]     ram_addr;
	logic [BLK_W-1:0]  ram_wdata;
	logic [BLK_W-1:0]  ram_rdata;
	logic              req_fire;
	logic              out_free;

	assign req.ready = cmd.req_ready;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= FIRST_BLOCK_RST;
			entries_q <= ENTRIES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FIRST_BLOCK:    first_q   <= cfg.data;
				CFG_ENTRIES_IN_USE: entries_q <= cfg.data[ENT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp the usable entry count to the table depth
	always_comb begin
		if (CW'(entries_q) > CW'(TABLE_DEPTH)) begin
			valid_cnt = VW'(TABLE_DEPTH);
		end else begin
			valid_cnt = VW'(entries_q);
		end
	end

	// map current block to a table index
	assign cur_off = cur_q - first_q;
	assign cur_idx = cur_off[IW-1:0];

	// block number under the scan pointer
	assign scan_num    = {1'b0, first_q} + VAL_W'(scan_q);
	assign scan_usable = (scan_num != '0) && (scan_num < VAL_W'(LINK_END));

	// latch request, follow links
	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q <= req.func;
			none_q <= req.block[VAL_W-1];
			cur_q  <= req.block[BLK_W-1:0];
		end else if (cmd.cur_load) begin
			cur_q <= ram_rdata;
		end
	end

	// scan and clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.cnt_clr) begin
			scan_q <= '0;
		end else if (cmd.cnt_inc) begin
			scan_q <= scan_q + VW'(1);
		end
	end

	// RAM address and write data
	assign ram_addr = (cmd.addr_sel == ADDR_SCAN) ? scan_q[IW-1:0] : cur_idx;

	always_comb begin
		unique case (cmd.wr_sel)
			WR_ZERO: ram_wdata = LINK_FREE;
			WR_END:  ram_wdata = LINK_END;
			WR_LINK: ram_wdata = scan_num[BLK_W-1:0];
			default: ram_wdata = LINK_FREE;
		endcase
	end

	bcat_ram #(
		.WIDTH (BLK_W),
		.DEPTH (TABLE_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// hold the result until the output register is free
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_sel)
				RES_NONE:  res_value_q <= '1;
				RES_ENTRY: res_value_q <= {1'b0, ram_rdata};
				RES_SCAN:  res_value_q <= {1'b0, scan_num[BLK_W-1:0]};
				default:   res_value_q <= '1;
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

	// status toward the controller
	always_comb begin
		stat.req_fire = req_fire;
		stat.func     = func_q;
		stat.none     = none_q;
		stat.in_range = (cur_q >= first_q) && (cur_off < BLK_W'(valid_cnt))
			&& (cur_q != LINK_FREE) && (cur_q != LINK_END);
		stat.ent_zero = (ram_rdata == LINK_FREE);
		stat.ent_end  = (ram_rdata == LINK_END);
		stat.scan_end = (scan_q >= valid_cnt);
		stat.scan_hit = (ram_rdata == LINK_FREE) && scan_usable;
		stat.clr_last = (scan_q == VW'(TABLE_DEPTH - 1));
		stat.out_free = out_free;
	end
endmodule

// ===== sv/bcat_ctrl.sv =====
// Controller state machine: clearing pass, decode, chain walk, free-entry
// scan and result hand-off. Drives the datapath by command struct.
// Depends on bcat_pkg.
module bcat_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcat_pkg::ctl_stat_t  stat,
	output bcat_pkg::ctl_cmd_t   cmd
);
	import bcat_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (stat.req_fire) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.func == FUNC_ALLOC) begin
					state_d = S_SCAN_RD;
				end else if (stat.none || !stat.in_range) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (stat.ent_zero) begin
					state_d = S_FINISH;
				end else if (stat.ent_end) begin
					state_d = (stat.func == FUNC_EXTEND) ? S_SCAN_RD : S_FINISH;
				end else if (stat.func == FUNC_FREE) begin
					state_d = S_DECODE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN_RD: begin
				state_d = stat.scan_end ? S_FINISH : S_SCAN_CK;
			end
			S_SCAN_CK: begin
				priority if (stat.scan_hit) begin
					state_d = (stat.func == FUNC_EXTEND) ? S_LINK : S_FINISH;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_LINK: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd.req_ready  = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.addr_sel   = ADDR_CUR;
		cmd.wr_sel     = WR_ZERO;
		cmd.cur_load   = 1'b0;
		cmd.cnt_clr    = 1'b0;
		cmd.cnt_inc    = 1'b0;
		cmd.res_set    = 1'b0;
		cmd.res_sel    = RES_NONE;
		cmd.res_status = STAT_OK;
		cmd.out_load   = 1'b0;
		unique case (state_q)
			// zero one entry per cycle
			S_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.addr_sel = ADDR_SCAN;
				cmd.wr_sel   = WR_ZERO;
				cmd.cnt_inc  = 1'b1;
			end
			S_IDLE: begin
				cmd.req_ready = 1'b1;
				cmd.cnt_clr   = 1'b1;
			end
			// check the block, read its entry (not for allocate)
			S_DECODE: begin
				priority if (stat.func == FUNC_ALLOC) begin
				end else if (stat.none) begin
					cmd.res_set = 1'b1;
				end else if (!stat.in_range) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STAT_RANGE;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			// act on the entry read
			S_EVAL: begin
				if (stat.func == FUNC_FREE) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_ZERO;
				end
				priority if (stat.ent_zero) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STAT_BROKEN;
				end else if (stat.ent_end) begin
					cmd.res_set = (stat.func != FUNC_EXTEND);
				end else if (stat.func == FUNC_FREE) begin
					cmd.cur_load = 1'b1;
				end else begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_ENTRY;
				end
			end
			S_SCAN_RD: begin
				if (stat.scan_end) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STAT_FULL;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_SCAN;
				end
			end
			// claim a free entry or advance
			S_SCAN_CK: begin
				if (stat.scan_hit) begin
					cmd.wr_en    = 1'b1;
					cmd.addr_sel = ADDR_SCAN;
					cmd.wr_sel   = WR_END;
					cmd.res_set  = 1'b1;
					cmd.res_sel  = RES_SCAN;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			// link the old chain end to the new block
			S_LINK: begin
				cmd.wr_en    = 1'b1;
				cmd.addr_sel = ADDR_CUR;
				cmd.wr_sel   = WR_LINK;
			end
			S_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== sv/block_chain_allocation_table.sv =====
// Block chain allocation table. After reset a clearing pass zeroes the link
// table, one entry a cycle; no request is taken then.
// One request at a time, from the accepting cycle to the output register:
// follow reads the entry of the block, allocate scans for a free entry,
// extend finds a free entry and links the chain end to it, free zeroes
// each chain link in turn; a stalled result holds off the next request.
module block_chain_allocation_table #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	bcat_req_if.sink   req,
	bcat_rsp_if.source rsp,
	bcat_cfg_if.sink   cfg
);
	import bcat_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	bcat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	bcat_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);
endmodule
